FILE: src/msx_pkg.sv
`timescale 1ns / 1ps
// Package for the MIPS subset execute unit: opcodes, syscall codes and the
// instruction, result and register file port types. No dependencies.
package msx_pkg;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_ADDI    = 4'd2;
    localparam logic [3:0] OP_LI      = 4'd3;
    localparam logic [3:0] OP_MULT    = 4'd4;
    localparam logic [3:0] OP_AND     = 4'd5;
    localparam logic [3:0] OP_OR      = 4'd6;
    localparam logic [3:0] OP_SLL     = 4'd7;
    localparam logic [3:0] OP_SLT     = 4'd8;
    localparam logic [3:0] OP_SLTI    = 4'd9;
    localparam logic [3:0] OP_LUI     = 4'd10;
    localparam logic [3:0] OP_LW      = 4'd11;
    localparam logic [3:0] OP_SW      = 4'd12;
    localparam logic [3:0] OP_SYSCALL = 4'd13;
    localparam logic [3:0] OP_NONE    = 4'd14;

    localparam logic [31:0] SYS_PRINT_INT = 32'd1;
    localparam logic [31:0] SYS_EXIT      = 32'd10;

    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;

    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic [4:0]         third_reg;
        logic signed [31:0] immediate;
    } instr_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               halt;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               reg_write;
        logic [4:0]         reg_index;
        logic signed [31:0] reg_value;
        logic               store_valid;
        logic [9:0]         store_address;
        logic signed [31:0] store_value;
        logic signed [31:0] hi_value;
        logic signed [31:0] lo_value;
    } result_t;

    typedef struct packed {
        logic       en;
        logic [4:0] addr_a;
        logic [4:0] addr_b;
        logic [4:0] addr_c;
    } rf_rd_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

endpackage

FILE: src/msx_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instructions and results.
// Depends on msx_pkg for the payload types.
interface msx_instr_if import msx_pkg::*; ();
    logic   valid;
    logic   ready;
    instr_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface msx_result_if import msx_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/mips_subset_execute_unit.sv
`timescale 1ns / 1ps
// Execute unit for a small MIPS32 integer subset: top level with the
// pipeline, data memory and HI/LO/PC state. Uses msx_pkg, msx_if, msx_regfile.
//
// Usage:
//   instr  - decoded instructions in (op, three register indices, immediate).
//   result - one transaction per instruction: next PC, halt, print, register
//            write, memory store and the HI/LO values after the instruction.
//   Both channels transfer when valid and ready are high at a rising edge.
// Path: an instruction passes the read stage and the write-back stage to the output register, which holds its result.
// Throughput: one instruction per cycle while result.ready is high; register
//   reads go through the synchronous register file at accept, the data memory
//   port is used at most once per instruction, in the read stage, and results
//   from the write-back stage are forwarded to the instruction behind it.
// Reset: registers, HI, LO and PC clear at once; the data memory is cleared
//   one word a cycle; instr.ready is low until it is cleared. MEM_DEPTH must be
//   a power of two (not enforced); addresses wrap on its low bits.
// Stall: when result.ready is low the output register, the write-back
//   stage and the read stage fill and hold, then instr.ready drops.
module mips_subset_execute_unit import msx_pkg::*;
#(
    parameter int MEM_DEPTH = 1024,
    parameter int PC_BITS   = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    msx_instr_if.sink     instr,
    msx_result_if.source  result
);

    localparam int AW = $clog2(MEM_DEPTH);

    // memory clearing pass
    logic [AW-1:0] clr_addr_reg;
    logic          clear_done_reg;

    // read stage
    logic   s1_valid_reg;
    instr_t s1_instr_reg;
    logic   s1_go;

    // write-back stage
    logic          s2_valid_reg;
    logic [3:0]    s2_op_reg;
    logic          s2_wr_en_reg;
    logic [4:0]    s2_idx_reg;
    logic [31:0]   s2_wval_reg;
    logic [63:0]   s2_prod_reg;
    logic [AW-1:0] s2_saddr_reg;
    logic [31:0]   s2_sval_reg;
    logic          s2_go;

    // architectural state outside the register file
    logic [31:0]        hi_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        v0_reg;
    logic [31:0]        a0_reg;
    logic [PC_BITS-1:0] pc_reg;
    logic [PC_BITS-1:0] pc_next;

    // output register
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t out_next;

    // data memory
    logic [31:0]   dmem [MEM_DEPTH];
    logic [31:0]   dmem_rdata_reg;
    logic          dmem_we;
    logic          dmem_re;
    logic [AW-1:0] dmem_waddr;
    logic [31:0]   dmem_wdata;

    // register file
    rf_rd_t      rf_rd;
    rf_wr_t      rf_wr;
    logic [31:0] rd_a;
    logic [31:0] rd_b;
    logic [31:0] rd_c;

    // read stage datapath
    logic [31:0]        opa;
    logic [31:0]        opb;
    logic [31:0]        opc;
    logic [31:0]        imm;
    logic [31:0]        sum_bi;
    logic [AW-1:0]      s1_addr;
    logic [31:0]        s1_wval;
    logic               s1_wr_en;
    logic signed [63:0] s1_prod;
    logic [31:0]        s2_result_val;

    // write-back stage decode
    logic s2_halt;
    logic s2_print;
    logic s2_mult;
    logic s2_store;

    logic accept;

    assign accept        = instr.valid && instr.ready;
    assign s2_go         = s2_valid_reg && (!out_valid_reg || result.ready);
    assign s1_go         = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign instr.ready   = clear_done_reg && (!s1_valid_reg || s1_go);
    assign result.valid  = out_valid_reg;
    assign result.payload = out_data_reg;

    // ---------------- memory clearing pass ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            clear_done_reg <= 1'b0;
        end
        else if (!clear_done_reg)
        begin
            if (clr_addr_reg == AW'(MEM_DEPTH - 1))
            begin
                clear_done_reg <= 1'b1;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // ---------------- register file ----------------
    always_comb
    begin
        rf_rd.en     = accept;
        rf_rd.addr_a = instr.payload.first_reg;
        rf_rd.addr_b = instr.payload.second_reg;
        rf_rd.addr_c = instr.payload.third_reg;
        rf_wr.en     = s2_go && s2_wr_en_reg;
        rf_wr.addr   = s2_idx_reg;
        rf_wr.data   = s2_result_val;
    end

    msx_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rf_rd),
        .wr    (rf_wr),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .rd_c  (rd_c)
    );

    // ---------------- read stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instr.payload;
        end
    end

    assign s2_result_val = (s2_op_reg == OP_LW) ? dmem_rdata_reg : s2_wval_reg;

    always_comb
    begin
        opa = (s2_valid_reg && s2_wr_en_reg && s2_idx_reg == s1_instr_reg.first_reg)
              ? s2_result_val : rd_a;
        opb = (s2_valid_reg && s2_wr_en_reg && s2_idx_reg == s1_instr_reg.second_reg)
              ? s2_result_val : rd_b;
        opc = (s2_valid_reg && s2_wr_en_reg && s2_idx_reg == s1_instr_reg.third_reg)
              ? s2_result_val : rd_c;
    end

    assign imm     = s1_instr_reg.immediate;
    assign sum_bi  = opb + imm;
    assign s1_addr = sum_bi[AW-1:0];
    assign s1_prod = 64'($signed(opa)) * 64'($signed(opb));

    always_comb
    begin
        case (s1_instr_reg.op)
            OP_ADD:  s1_wval = opb + opc;
            OP_SUB:  s1_wval = opb - opc;
            OP_ADDI: s1_wval = sum_bi;
            OP_LI:   s1_wval = imm;
            OP_AND:  s1_wval = opb & opc;
            OP_OR:   s1_wval = opb | opc;
            OP_SLL:  s1_wval = opb << imm[4:0];
            OP_SLT:  s1_wval = {31'b0, $signed(opb) < $signed(opc)};
            OP_SLTI: s1_wval = {31'b0, $signed(opb) < $signed(imm)};
            OP_LUI:  s1_wval = {imm[15:0], 16'h0000};
            default: s1_wval = '0;
        endcase
        s1_wr_en = (s1_instr_reg.op inside {OP_ADD, OP_SUB, OP_ADDI, OP_LI,
                                            [OP_AND:OP_LW]})
                   && (s1_instr_reg.first_reg != '0);
    end

    // ---------------- data memory ----------------
    always_comb
    begin
        dmem_re = s1_go && (s1_instr_reg.op == OP_LW);
        if (!clear_done_reg)
        begin
            dmem_we    = 1'b1;
            dmem_waddr = clr_addr_reg;
            dmem_wdata = '0;
        end
        else
        begin
            dmem_we    = s1_go && (s1_instr_reg.op == OP_SW);
            dmem_waddr = s1_addr;
            dmem_wdata = opa;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            dmem[dmem_waddr] <= dmem_wdata;
        end
        if (dmem_re)
        begin
            dmem_rdata_reg <= dmem[s1_addr];
        end
    end

    // ---------------- write-back stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_op_reg    <= s1_instr_reg.op;
            s2_wr_en_reg <= s1_wr_en;
            s2_idx_reg   <= s1_instr_reg.first_reg;
            s2_wval_reg  <= s1_wval;
            s2_prod_reg  <= s1_prod;
            s2_saddr_reg <= s1_addr;
            s2_sval_reg  <= opa;
        end
    end

    always_comb
    begin
        s2_mult  = (s2_op_reg == OP_MULT);
        s2_store = (s2_op_reg == OP_SW);
        s2_halt  = (s2_op_reg == OP_SYSCALL) && (v0_reg == SYS_EXIT);
        s2_print = (s2_op_reg == OP_SYSCALL) && (v0_reg == SYS_PRINT_INT);
        pc_next  = s2_halt ? pc_reg : pc_reg + PC_BITS'(1);

        out_next.next_pc       = 16'(pc_next);
        out_next.halt          = s2_halt;
        out_next.print_valid   = s2_print;
        out_next.print_value   = s2_print ? a0_reg : '0;
        out_next.reg_write     = s2_wr_en_reg;
        out_next.reg_index     = s2_wr_en_reg ? s2_idx_reg : '0;
        out_next.reg_value     = s2_wr_en_reg ? s2_result_val : '0;
        out_next.store_valid   = s2_store;
        out_next.store_address = s2_store ? 10'(s2_saddr_reg) : '0;
        out_next.store_value   = s2_store ? s2_sval_reg : '0;
        out_next.hi_value      = s2_mult ? s2_prod_reg[63:32] : hi_reg;
        out_next.lo_value      = s2_mult ? s2_prod_reg[31:0] : lo_reg;
    end

    // commit state and load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg        <= '0;
            lo_reg        <= '0;
            v0_reg        <= '0;
            a0_reg        <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
                pc_reg        <= pc_next;
                if (s2_mult)
                begin
                    hi_reg <= s2_prod_reg[63:32];
                    lo_reg <= s2_prod_reg[31:0];
                end
                if (s2_wr_en_reg && s2_idx_reg == REG_V0)
                begin
                    v0_reg <= s2_result_val;
                end
                if (s2_wr_en_reg && s2_idx_reg == REG_A0)
                begin
                    a0_reg <= s2_result_val;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            out_data_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done_reg |-> !instr.ready)
        else $error("instruction taken during memory clear");

    a_no_write_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> rf_wr.addr != '0)
        else $error("write to register zero");

    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go && s2_halt |=> pc_reg == $past(pc_reg))
        else $error("PC advanced on halt");

    a_store_excludes_write: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.payload.store_valid && result.payload.reg_write))
        else $error("store and register write in one result");

    a_single_dmem_access: assert property (@(posedge clk) disable iff (!rst_n)
        clear_done_reg |-> !(dmem_we && dmem_re))
        else $error("data memory read and write in one cycle");
`endif

endmodule

FILE: src/msx_regfile.sv
`timescale 1ns / 1ps
// General register file: two synchronous copies for three read ports, write-first
// bypass, and valid bits so that unwritten registers read as zero. Uses msx_pkg.
module msx_regfile import msx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rf_rd_t      rd,
    input  rf_wr_t      wr,
    output logic [31:0] rd_a,
    output logic [31:0] rd_b,
    output logic [31:0] rd_c
);

    logic [31:0] ab_mem [32];
    logic [31:0] c_mem  [32];
    logic [31:0] valid_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic [31:0] rd_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ab_mem[wr.addr] <= wr.data;
            c_mem[wr.addr]  <= wr.data;
        end
        if (rd.en)
        begin
            rd_a_reg <= (wr.en && wr.addr == rd.addr_a) ? wr.data :
                        (valid_reg[rd.addr_a] ? ab_mem[rd.addr_a] : '0);
            rd_b_reg <= (wr.en && wr.addr == rd.addr_b) ? wr.data :
                        (valid_reg[rd.addr_b] ? ab_mem[rd.addr_b] : '0);
            rd_c_reg <= (wr.en && wr.addr == rd.addr_c) ? wr.data :
                        (valid_reg[rd.addr_c] ? c_mem[rd.addr_c] : '0);
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;
    assign rd_c = rd_c_reg;

endmodule
